[design/srs_pkg.sv]
// Package for the sorted range search block: function codes and field widths.
// No dependencies; imported by the interfaces, the search module and the testbench.
package srs_pkg;

  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned IDX_W   = 10;

  typedef logic [FUNC_W-1:0]         func_t;
  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [IDX_W-1:0]          idx_t;

  localparam func_t FUNC_APPEND = 2'd0;
  localparam func_t FUNC_QUERY  = 2'd1;
  localparam func_t FUNC_CLEAR  = 2'd2;

endpackage

[design/srs_if.sv]
// Handshake interfaces for the command and result channels of the search block.
// Depends on srs_pkg for the payload types.
interface srs_in_if
  import srs_pkg::*;
();
  logic   valid;
  logic   ready;
  func_t  func;
  value_t value;

  modport source (output valid, output func, output value, input ready);
  modport sink   (input valid, input func, input value, output ready);
endinterface

interface srs_out_if
  import srs_pkg::*;
();
  logic valid;
  logic ready;
  logic found;
  idx_t first_index;
  idx_t last_index;

  modport source (output valid, output found, output first_index, output last_index,
                  input ready);
  modport sink   (input valid, input found, input first_index, input last_index,
                  output ready);
endinterface

[design/srs_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module srs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

[design/sorted_range_search.sv]
// Sorted range search: element store in one RAM; a query runs a first-occurrence
// binary search and, after a hit, a last-occurrence one. Append and clear are
// handled in the idle state. Each probe passes through a RAM read state, then a
// compare state; a pass ends in a read state whose bounds have crossed.
// One item is in work at a time. Reset clears the entry count and the control
// state; the store is not cleared, as only appended entries are ever read.
module sorted_range_search
  import srs_pkg::*;
#(
  parameter int unsigned DEPTH = 1024
) (
  input logic         clk_i,
  input logic         rst_ni,
  srs_in_if.sink      in_i,
  srs_out_if.source   out_o
);

  // Address width for the store, count width that can hold DEPTH itself,
  // and a signed width for the search bounds (right bound may go to -1).
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = CW + 1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_CMP  = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [CW-1:0]        count_q, count_d;
  logic signed [SW-1:0] lo_q, lo_d, hi_q, hi_d;
  logic [CW-1:0]        mid_q, mid_d;
  logic                 pass_last_q, pass_last_d;
  logic                 hit_q, hit_d;
  logic [CW-1:0]        hit_idx_q, hit_idx_d;
  logic [CW-1:0]        first_idx_q, first_idx_d;
  value_t               target_q, target_d;

  logic                 out_valid_q, out_valid_d;
  logic                 out_found_q, out_found_d;
  idx_t                 out_first_q, out_first_d;
  idx_t                 out_last_q, out_last_d;

  // Store port signals
  logic                 ram_we;
  logic                 ram_re;
  logic [VALUE_W-1:0]   ram_rdata;
  value_t               probe_val;

  logic                 in_fire;
  logic                 out_free;
  logic signed [SW-1:0] span;
  logic signed [SW-1:0] mid_w;
  logic signed [SW-1:0] mid_s;
  logic signed [SW-1:0] count_m1;
  logic                 in_range;
  logic [IDX_W+CW-1:0]  first_ext, last_ext;

  // Accept items only between queries; this keeps appends off the store
  // while a search reads it, so no forwarding is needed.
  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;

  // Probe at left + (right - left) / 2; span is non-negative whenever used.
  assign span     = hi_q - lo_q;
  assign mid_w    = lo_q + (span >>> 1);
  assign mid_s    = $signed({1'b0, mid_q});
  assign count_m1 = $signed({1'b0, count_q}) - SW'(1);
  assign in_range = (lo_q <= hi_q);
  assign probe_val = $signed(ram_rdata);

  // Indices leave masked to the result width.
  assign first_ext = {{IDX_W{1'b0}}, first_idx_q};
  assign last_ext  = {{IDX_W{1'b0}}, hit_idx_q};

  assign ram_we = in_fire && (in_i.func == FUNC_APPEND) && (count_q < CW'(DEPTH));
  assign ram_re = (state_q == ST_READ) && in_range;

  srs_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (in_i.value),
    .re_i    (ram_re),
    .raddr_i (mid_w[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    pass_last_d = pass_last_q;
    hit_d       = hit_q;
    hit_idx_d   = hit_idx_q;
    first_idx_d = first_idx_q;
    target_d    = target_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_found_d = out_found_q;
    out_first_d = out_first_q;
    out_last_d  = out_last_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (in_i.func)
            FUNC_APPEND: begin
              // Drop the element when the store is full.
              if (count_q < CW'(DEPTH)) begin
                count_d = count_q + CW'(1);
              end
            end
            FUNC_CLEAR: begin
              count_d = '0;
            end
            FUNC_QUERY: begin
              // Start the first-occurrence pass over the loaded entries.
              target_d    = in_i.value;
              lo_d        = '0;
              hi_d        = count_m1;
              hit_d       = 1'b0;
              pass_last_d = 1'b0;
              state_d     = ST_READ;
            end
            default: begin
              // Unused code: ignore the item.
            end
          endcase
        end
      end

      ST_READ: begin
        if (in_range) begin
          // Read issued this cycle; hold the probe index for the compare.
          mid_d   = mid_w[CW-1:0];
          state_d = ST_CMP;
        end else if (!pass_last_q && hit_q) begin
          // First pass hit: keep its index and run the last-occurrence pass.
          first_idx_d = hit_idx_q;
          lo_d        = '0;
          hi_d        = count_m1;
          hit_d       = 1'b0;
          pass_last_d = 1'b1;
        end else if (out_free) begin
          // Search over: load the result, or wait for the output slot.
          out_valid_d = 1'b1;
          out_found_d = pass_last_q && hit_q;
          out_first_d = (pass_last_q && hit_q) ? first_ext[IDX_W-1:0] : '0;
          out_last_d  = (pass_last_q && hit_q) ? last_ext[IDX_W-1:0]  : '0;
          state_d     = ST_IDLE;
        end
      end

      ST_CMP: begin
        state_d = ST_READ;
        if (probe_val == target_q) begin
          hit_d     = 1'b1;
          hit_idx_d = mid_q;
          if (pass_last_q) begin
            lo_d = mid_s + SW'(1);
          end else begin
            hi_d = mid_s - SW'(1);
          end
        end else if (probe_val < target_q) begin
          lo_d = mid_s + SW'(1);
        end else begin
          hi_d = mid_s - SW'(1);
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      pass_last_q <= 1'b0;
      hit_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      pass_last_q <= pass_last_d;
      hit_q       <= hit_d;
    end
  end

  // Datapath registers need no reset.
  always_ff @(posedge clk_i) begin
    lo_q        <= lo_d;
    hi_q        <= hi_d;
    mid_q       <= mid_d;
    hit_idx_q   <= hit_idx_d;
    first_idx_q <= first_idx_d;
    target_q    <= target_d;
    out_found_q <= out_found_d;
    out_first_q <= out_first_d;
    out_last_q  <= out_last_d;
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.found       = out_found_q;
  assign out_o.first_index = out_first_q;
  assign out_o.last_index  = out_last_q;

endmodule

[tb/tb_sorted_range_search.sv]
`timescale 1ns / 100ps
// Self-checking testbench for sorted_range_search: appends, clears and queries with checked answers.
// Depends on srs_pkg and the srs_in_if / srs_out_if interfaces of the design.
module tb_sorted_range_search;
  import srs_pkg::*;

  localparam int unsigned DEPTH          = 1024;
  localparam int          RESET_CYCLES   = 12;
  localparam int          RANDOM_ITEMS   = 700;
  // Allow for the longest query plus slack before calling the run drained.
  localparam int          DRAIN_CYCLES   = 100;
  // Slowest legal silence: one query, a long receiver stall and a sender gap.
  localparam int          WATCHDOG_LIMIT = 2000;

  localparam func_t  FUNC_UNUSED = 2'd3;
  localparam value_t VAL_MIN     = 32'sh8000_0000;
  localparam value_t VAL_MAX     = 32'sh7fff_ffff;

  typedef struct packed {
    func_t  func;
    value_t value;
  } cmd_t;

  typedef struct packed {
    logic found;
    idx_t first_index;
    idx_t last_index;
  } answer_t;

  // Receiver stall patterns: always open, coin flip, mostly closed.
  typedef enum int {RX_OPEN, RX_RANDOM, RX_SPARSE} rx_mode_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  srs_in_if  cmd_if ();
  srs_out_if res_if ();

  sorted_range_search #(
    .DEPTH(DEPTH)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (cmd_if),
    .out_o (res_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 0;
  end

  // ---------------------------------------------------------------------------
  // Search model: a private copy of the element store and its fill count.
  // Entries at or above the count are never read, so unwritten slots stay X.
  // ---------------------------------------------------------------------------
  value_t      model_store [DEPTH];
  int unsigned model_count;

  cmd_t    pending_cmds[$];     // items waiting for the driver
  answer_t pending_answers[$];  // answers predicted but not yet seen

  // Generator-side view of what is loaded, used to aim query targets at hits.
  value_t gen_loaded[$];

  int accepted_items;
  int answers_checked;
  int answers_found;
  int fail_count;
  int idle_cycles;
  bit timed_out;

  // Binary search with the probe at lo + (hi - lo) / 2. On a match, step left
  // to find the first occurrence or right to find the last one.
  function automatic int search_bound(value_t target, bit toward_last);
    int lo;
    int hi;
    int mid;
    int hit;
    lo  = 0;
    hi  = int'(model_count) - 1;
    hit = -1;
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      if (model_store[mid] == target) begin
        hit = mid;
        if (toward_last) lo = mid + 1;
        else hi = mid - 1;
      end else if (model_store[mid] < target) begin
        lo = mid + 1;
      end else begin
        hi = mid - 1;
      end
    end
    return hit;
  endfunction

  // Update the model for one accepted item and queue the answer of a query.
  function automatic void accept_command(cmd_t c);
    int      first;
    int      last;
    answer_t ans;
    case (c.func)
      FUNC_APPEND: begin
        // Drop the element when the store is already full.
        if (model_count < DEPTH) begin
          model_store[model_count] = c.value;
          model_count++;
        end
      end
      FUNC_CLEAR: model_count = 0;
      FUNC_QUERY: begin
        ans   = '0;
        first = search_bound(c.value, 1'b0);
        if (first >= 0) begin
          last            = search_bound(c.value, 1'b1);
          ans.found       = 1'b1;
          ans.first_index = idx_t'(first);
          ans.last_index  = idx_t'(last);
        end
        pending_answers.push_back(ans);
      end
      default: ;  // unused code: no effect, no answer
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus building blocks
  // ---------------------------------------------------------------------------
  function automatic void push_cmd(func_t f, value_t v);
    cmd_t c;
    c.func  = f;
    c.value = v;
    pending_cmds.push_back(c);
    if (f == FUNC_APPEND && gen_loaded.size() < DEPTH) gen_loaded.push_back(v);
    if (f == FUNC_CLEAR) gen_loaded.delete();
  endfunction

  // Half the targets hit a loaded value, some sit just beside one, the rest
  // are extremes or anything at all.
  function automatic value_t pick_target();
    int k;
    int n;
    k = $urandom_range(0, 9);
    n = gen_loaded.size();
    if (n != 0 && k < 5) return gen_loaded[$urandom_range(0, n - 1)];
    if (n != 0 && k == 5) return gen_loaded[$urandom_range(0, n - 1)] - value_t'(1);
    if (n != 0 && k < 8) return gen_loaded[$urandom_range(0, n - 1)] + value_t'(1);
    if (k == 8) return $urandom_range(0, 1) ? VAL_MIN : VAL_MAX;
    return value_t'($urandom);
  endfunction

  function automatic int issue_queries(int n);
    for (int i = 0; i < n; i++) push_cmd(FUNC_QUERY, pick_target());
    return n;
  endfunction

  // Non-decreasing run with plenty of duplicates, sometimes pinned to the
  // bottom or the top of the signed range.
  function automatic int load_sorted_run(int len);
    longint cur;
    int     kind;
    int     step;
    kind = $urandom_range(0, 3);
    case (kind)
      0:       cur = longint'(VAL_MIN);
      1:       cur = longint'(VAL_MAX) - longint'(len) * 2;
      default: cur = longint'($signed($urandom));
    endcase
    for (int i = 0; i < len; i++) begin
      push_cmd(FUNC_APPEND, value_t'(cur));
      if ($urandom_range(0, 9) == 0) step = $urandom_range(0, 1 << 20);
      else if ($urandom_range(0, 2) == 0) step = 0;
      else step = $urandom_range(1, 3);
      cur = cur + step;
      if (cur > longint'(VAL_MAX)) cur = longint'(VAL_MAX);
    end
    return len;
  endfunction

  function automatic int run_length();
    if ($urandom_range(0, 7) == 0) return $urandom_range(41, 300);
    return $urandom_range(1, 40);
  endfunction

  function automatic void build_directed();
    push_cmd(FUNC_QUERY, 32'sd0);        // empty store after reset
    push_cmd(FUNC_CLEAR, 32'sd0);
    push_cmd(FUNC_QUERY, VAL_MIN);       // empty store after a clear
    push_cmd(FUNC_APPEND, VAL_MIN);
    push_cmd(FUNC_APPEND, -32'sd1);
    push_cmd(FUNC_APPEND, 32'sd0);
    push_cmd(FUNC_APPEND, 32'sd0);
    push_cmd(FUNC_APPEND, VAL_MAX);
    push_cmd(FUNC_QUERY, VAL_MIN);
    push_cmd(FUNC_QUERY, VAL_MAX);
    push_cmd(FUNC_QUERY, 32'sd0);        // duplicate pair
    push_cmd(FUNC_QUERY, -32'sd1);
    push_cmd(FUNC_QUERY, 32'sd5);        // miss between entries
    push_cmd(FUNC_QUERY, VAL_MAX - 32'sd1);
    push_cmd(FUNC_UNUSED, 32'sd0);       // ignored code, must not answer
    push_cmd(FUNC_QUERY, 32'sd0);
    push_cmd(FUNC_CLEAR, 32'sd0);
    push_cmd(FUNC_QUERY, 32'sd0);        // old contents kept but unused
    push_cmd(FUNC_APPEND, 32'sd7);
    push_cmd(FUNC_QUERY, 32'sd7);
    push_cmd(FUNC_QUERY, 32'sd6);
    push_cmd(FUNC_QUERY, 32'sd8);
  endfunction

  function automatic void build_random();
    int  count;
    int  n;
    func_t f;
    count      = 0;
    while (count < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          // Mostly well-formed: a clear (most of the time), sorted load, queries.
          if ($urandom_range(0, 5) != 0) begin
            push_cmd(FUNC_CLEAR, value_t'($urandom));
            count++;
          end
          count += load_sorted_run(run_length());
          count += issue_queries($urandom_range(4, 12));
        end
        6: begin
          // Unsorted content: answers still follow the probe order.
          for (int i = 0; i < $urandom_range(1, 20); i++) begin
            push_cmd(FUNC_APPEND, value_t'($urandom));
            count++;
          end
          count += issue_queries($urandom_range(3, 8));
        end
        7: begin
          // Noise of any code, the unused one included.
          n = $urandom_range(1, 10);
          for (int i = 0; i < n; i++) begin
            f = func_t'($urandom_range(0, 3));
            push_cmd(f, value_t'($urandom));
            if (f != FUNC_UNUSED) count++;
          end
        end
        8: count += issue_queries($urandom_range(3, 8));
        default: begin
          // Extend the current contents without a clear.
          count += load_sorted_run($urandom_range(1, 20));
          count += issue_queries($urandom_range(2, 6));
        end
      endcase
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: bursts of back-to-back items separated by random gaps. Valid stays
  // high across an acceptance when the burst goes on, with one assignment.
  // ---------------------------------------------------------------------------
  int burst_left;
  int gap_left;

  always @(posedge clk_i) begin : driver
    logic nxt_valid;
    bit   load;
    cmd_t nxt_cmd;
    if (!rst_ni) begin
      cmd_if.valid <= 1'b0;
      burst_left   = 0;
      gap_left     = 0;
    end else begin
      nxt_valid = cmd_if.valid;
      load      = 1'b0;
      nxt_cmd   = '0;
      if (cmd_if.valid && cmd_if.ready) begin
        // Values seen here are the ones the block took at this edge.
        accept_command({cmd_if.func, cmd_if.value});
        accepted_items++;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid && pending_cmds.size() != 0) begin
        if (burst_left != 0) begin
          load = 1'b1;
        end else if (gap_left != 0) begin
          gap_left--;
        end else begin
          // Start a new burst; now and then a long one with no gap after it.
          if ($urandom_range(0, 3) == 0) begin
            burst_left = $urandom_range(32, 96);
            gap_left   = 0;
          end else begin
            burst_left = $urandom_range(1, 16);
            gap_left   = $urandom_range(1, 12);
          end
          load = 1'b1;
        end
      end
      if (load) begin
        nxt_cmd   = pending_cmds.pop_front();
        nxt_valid = 1'b1;
        burst_left--;
        cmd_if.func  <= nxt_cmd.func;
        cmd_if.value <= nxt_cmd.value;
      end
      cmd_if.valid <= nxt_valid;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare each accepted answer with the oldest prediction, and
  // vary the ready pattern in stretches of random length.
  // ---------------------------------------------------------------------------
  rx_mode_e rx_mode = RX_OPEN;
  int       mode_left = 0;

  always @(posedge clk_i) begin : monitor
    answer_t want;
    logic    rdy;
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) begin
        if (pending_answers.size() == 0) begin
          $error("answer with no query pending: found %0d first %0d last %0d",
                 res_if.found, res_if.first_index, res_if.last_index);
          fail_count++;
        end else begin
          want = pending_answers.pop_front();
          answers_checked++;
          if (want.found) answers_found++;
          if (res_if.found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, res_if.found);
            fail_count++;
          end
          if (res_if.first_index !== want.first_index) begin
            $error("first_index: expected %0d, got %0d", want.first_index, res_if.first_index);
            fail_count++;
          end
          if (res_if.last_index !== want.last_index) begin
            $error("last_index: expected %0d, got %0d", want.last_index, res_if.last_index);
            fail_count++;
          end
        end
      end
      if (mode_left == 0) begin
        rx_mode   = rx_mode_e'($urandom_range(0, 2));
        mode_left = $urandom_range(20, 200);
      end else begin
        mode_left--;
      end
      case (rx_mode)
        RX_OPEN:   rdy = 1'b1;
        RX_RANDOM: rdy = $urandom_range(0, 1);
        default:   rdy = ($urandom_range(0, 7) == 0);
      endcase
      res_if.ready <= rdy;
    end
  end

  // Watchdog: count cycles with no handshake on either channel.
  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  // ---------------------------------------------------------------------------
  // Main sequence: build all items, release reset, wait for the drain, report.
  // ---------------------------------------------------------------------------
  initial begin : sequencer
    rst_ni       = 1'b0;
    cmd_if.valid = 1'b0;
    cmd_if.func  = FUNC_APPEND;
    cmd_if.value = '0;
    res_if.ready = 1'b0;
    model_count  = 0;
    fail_count   = 0;
    timed_out    = 1'b0;
    build_directed();
    build_random();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Valid covers the edge where the last item is taken but not yet predicted.
    while (!timed_out &&
           (pending_cmds.size() != 0 || cmd_if.valid || pending_answers.size() != 0)) begin
      @(posedge clk_i);
      if (idle_cycles >= WATCHDOG_LIMIT) timed_out = 1'b1;
    end
    // Let any stray answer show up before the verdict.
    if (!timed_out) repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("run covered %0d items, %0d answers checked (%0d hits), %0d failures",
             accepted_items, answers_checked, answers_found, fail_count);
    $display("including empty, cleared, duplicate-heavy and unsorted store contents");
    if (timed_out)
      $display("watchdog expired after %0d cycles with no handshake", idle_cycles);
    if (!timed_out && fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[files.f]
design/srs_pkg.sv
design/srs_if.sv
design/srs_ram.sv
design/sorted_range_search.sv
tb/tb_sorted_range_search.sv
